/* hw/rtl/text_console_char_writer_unit_assert.svh */
// Assertion macros for the text console character writer.
`ifndef TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a condition at every clock edge out of reset.
`define TCW_ASSERT(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("tcw: assertion failed");
// Check a consequence in the same cycle as its cause.
`define TCW_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcw: assertion failed");
// Check a consequence in the cycle after its cause.
`define TCW_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcw: assertion failed");
`else
`define TCW_ASSERT(name, expr)
`define TCW_ASSERT_IMPL(name, ante, cons)
`define TCW_ASSERT_NEXT(name, ante, cons)
`endif
`endif

/* hw/rtl/tcw_pkg.sv */
// Package with constants, codes and sequencer states of the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Character and attribute constants
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] RESET_ATTR   = 8'h0F;

    // Operation codes
    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_SET   = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_CLEAR,
        ST_PROBE,
        ST_RESULT
    } state_t;

endpackage

/* hw/rtl/tcw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; hold data when not reading
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/text_console_char_writer_unit.sv */
// Top level of the text console character writer: sequencer, cursor and cell store.
//
//  Channel  | Signals                                  | Direction | Flow control
//  ---------+------------------------------------------+-----------+-------------
//  in       | mode, char_code, new_col, new_row,       | to unit   | in_valid/in_ready
//           | probe_col, probe_row                     |           |
//  out      | cursor_col, cursor_row, cursor_pos,      | from unit | out_valid/out_ready
//           | probe_char, probe_attr                   |           |
//  cfg      | cfg_wdata (text attribute)               | to unit   | cfg_we, no wait
//
// A character, set or unused-mode transaction passes through accept, execute, probe read
// and result. A scroll and a clear add a sweep of the cell store through its single write
// port, one cell per cycle. After reset a clearing pass over all COLUMNS*ROWS cells
// (2000 by default) fills the store with blank cells; in_ready stays low meanwhile. The
// output register lets the next transaction be accepted while a result waits; a stalled
// output holds the sequencer in its result state.
`timescale 1ns / 1ps
`include "text_console_char_writer_unit_assert.svh"
module text_console_char_writer_unit #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [7:0]                       cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       mode,
    input  logic [7:0]                       char_code,
    input  logic [7:0]                       new_col,
    input  logic [7:0]                       new_row,
    input  logic [$clog2(COLUMNS)-1:0]       probe_col,
    input  logic [$clog2(ROWS)-1:0]          probe_row,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [$clog2(COLUMNS)-1:0]       cursor_col,
    output logic [$clog2(ROWS)-1:0]          cursor_row,
    output logic [$clog2(COLUMNS*ROWS)-1:0]  cursor_pos,
    output logic [7:0]                       probe_char,
    output logic [7:0]                       probe_attr
);

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);

    // Control state
    tcw_pkg::state_t     state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [7:0]          attr_reg;
    logic                out_valid_reg, out_valid_next;

    // Captured transaction
    logic [1:0]          mode_reg;
    logic [7:0]          char_reg;
    logic [7:0]          ncol_reg;
    logic [7:0]          nrow_reg;
    logic [COL_W-1:0]    pcol_reg;
    logic [ROW_W-1:0]    prow_reg;
    logic                probe_ok_reg;

    // Result register
    logic [COL_W-1:0]    out_col_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic [ADDR_W-1:0]   out_pos_reg;
    logic [7:0]          out_char_reg;
    logic [7:0]          out_attr_reg;

    // Shared address unit and store port signals
    logic [ROW_W-1:0]    au_row;
    logic [COL_W-1:0]    au_col;
    logic [ADDR_W-1:0]   au_addr;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [15:0]         ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [15:0]         ram_rdata;
    logic                accept;
    logic                load_out;
    logic [CNT_W-1:0]    cnt_prev;

    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == tcw_pkg::ST_RESULT) && (!out_valid_reg || out_ready);
    assign cnt_prev = cnt_reg - CNT_W'(1);

    // Shared row-times-columns-plus-column unit
    assign au_addr = ADDR_W'(au_row) * ADDR_W'(COLUMNS) + ADDR_W'(au_col);

    // Cell store
    tcw_ram #(
        .WIDTH(16),
        .DEPTH(CELLS)
    ) u_cells (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Next state of the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_EXEC:
            begin
                state_next = tcw_pkg::ST_PROBE;
                if (mode_reg == tcw_pkg::MODE_CLEAR)
                begin
                    state_next = tcw_pkg::ST_CLEAR;
                end
                else if (mode_reg == tcw_pkg::MODE_PUT && char_reg != tcw_pkg::CH_BACKSPACE
                         && row_reg == ROW_W'(ROWS - 1)
                         && (char_reg == tcw_pkg::CH_NEWLINE
                             || col_reg == COL_W'(COLUMNS - 1)))
                begin
                    state_next = tcw_pkg::ST_SCROLL;
                end
            end
            tcw_pkg::ST_SCROLL:
            begin
                if (cnt_reg == CNT_W'(CELLS))
                begin
                    state_next = tcw_pkg::ST_PROBE;
                end
            end
            tcw_pkg::ST_CLEAR:
            begin
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = tcw_pkg::ST_PROBE;
                end
            end
            tcw_pkg::ST_PROBE:
            begin
                state_next = tcw_pkg::ST_RESULT;
            end
            tcw_pkg::ST_RESULT:
            begin
                if (load_out)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // Cursor, sweep counter and output handshake updates
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        cnt_next       = '0;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        case (state_reg)
            tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR, tcw_pkg::ST_SCROLL:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            tcw_pkg::ST_EXEC:
            begin
                case (mode_reg)
                    tcw_pkg::MODE_PUT:
                    begin
                        if (char_reg == tcw_pkg::CH_BACKSPACE)
                        begin
                            if (col_reg != '0)
                            begin
                                col_next = col_reg - COL_W'(1);
                            end
                        end
                        else if (char_reg == tcw_pkg::CH_NEWLINE
                                 || col_reg == COL_W'(COLUMNS - 1))
                        begin
                            col_next = '0;
                            if (row_reg != ROW_W'(ROWS - 1))
                            begin
                                row_next = row_reg + ROW_W'(1);
                            end
                        end
                        else
                        begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                    tcw_pkg::MODE_CLEAR:
                    begin
                        col_next = '0;
                        row_next = '0;
                    end
                    tcw_pkg::MODE_SET:
                    begin
                        if (ncol_reg < 8'(COLUMNS))
                        begin
                            col_next = ncol_reg[COL_W-1:0];
                        end
                        if (nrow_reg < 8'(ROWS))
                        begin
                            row_next = nrow_reg[ROW_W-1:0];
                        end
                    end
                    default:
                    begin
                        col_next = col_reg;
                    end
                endcase
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // Store port, address unit and handshake outputs of the sequencer
    always_comb
    begin
        in_ready  = 1'b0;
        au_row    = row_reg;
        au_col    = col_reg;
        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(cnt_reg);
        ram_wdata = {attr_reg, tcw_pkg::CH_SPACE};
        ram_re    = 1'b0;
        ram_raddr = au_addr;
        case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::CH_SPACE};
            end
            tcw_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            tcw_pkg::ST_EXEC:
            begin
                ram_waddr = au_addr;
                if (mode_reg == tcw_pkg::MODE_PUT)
                begin
                    if (char_reg == tcw_pkg::CH_BACKSPACE)
                    begin
                        // blank the cell left of the cursor
                        au_col = col_reg - COL_W'(1);
                        ram_we = (col_reg != '0);
                    end
                    else if (char_reg != tcw_pkg::CH_NEWLINE)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {attr_reg, char_reg};
                    end
                end
            end
            tcw_pkg::ST_SCROLL:
            begin
                // read one row ahead, write the previous cell
                ram_re    = (cnt_reg < CNT_W'(CELLS - COLUMNS));
                ram_raddr = ADDR_W'(cnt_reg) + ADDR_W'(COLUMNS);
                ram_we    = (cnt_reg != '0);
                ram_waddr = ADDR_W'(cnt_prev);
                if (cnt_reg <= CNT_W'(CELLS - COLUMNS))
                begin
                    ram_wdata = ram_rdata;
                end
            end
            tcw_pkg::ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            tcw_pkg::ST_PROBE:
            begin
                au_row = prow_reg;
                au_col = pcol_reg;
                ram_re = probe_ok_reg;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::ST_INIT;
            cnt_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= tcw_pkg::RESET_ATTR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
        end
    end

    // Capture the accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg     <= mode;
            char_reg     <= char_code;
            ncol_reg     <= new_col;
            nrow_reg     <= new_row;
            pcol_reg     <= probe_col;
            prow_reg     <= probe_row;
            probe_ok_reg <= (probe_col < COL_W'(COLUMNS - 1) || probe_col == COL_W'(COLUMNS - 1))
                            && (probe_row < ROW_W'(ROWS - 1) || probe_row == ROW_W'(ROWS - 1));
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_col_reg  <= col_reg;
            out_row_reg  <= row_reg;
            out_pos_reg  <= au_addr;
            out_char_reg <= probe_ok_reg ? ram_rdata[7:0] : 8'h00;
            out_attr_reg <= probe_ok_reg ? ram_rdata[15:8] : 8'h00;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cursor_col = out_col_reg;
    assign cursor_row = out_row_reg;
    assign cursor_pos = out_pos_reg;
    assign probe_char = out_char_reg;
    assign probe_attr = out_attr_reg;

    // Checks on the cursor, the sequencer and the result
    `TCW_ASSERT(a_col_in_range, col_reg <= COL_W'(COLUMNS - 1))
    `TCW_ASSERT(a_row_in_range, row_reg <= ROW_W'(ROWS - 1))
    `TCW_ASSERT_NEXT(a_accept_starts_exec, accept, state_reg == tcw_pkg::ST_EXEC)
    `TCW_ASSERT_IMPL(a_pos_matches_cursor, out_valid,
        cursor_pos == ADDR_W'(cursor_row) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_col))

endmodule
